[design/sd_pkg.sv]
// shared constants for the segment distance block
`default_nettype none

package sd_pkg;

    // coordinate width in bits, signed fixed point
    localparam int COORD_BITS_DEF = 16;

    // opcodes of a query word
    localparam logic OP_POINT = 1'b0;
    localparam logic OP_SEGMENT = 1'b1;

    // cycles from the accept edge to the edge that takes the result
    function automatic int latency(input int cb);
        return cb + 13;
    endfunction

endpackage

`default_nettype wire

[design/sd_prep.sv]
// segment to point front end: squared distance as numerator over denominator
`default_nettype none

module sd_prep #(
    parameter int CB = sd_pkg::COORD_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    input  wire logic                 i_tag,
    input  wire logic signed [CB-1:0] i_sx1,
    input  wire logic signed [CB-1:0] i_sy1,
    input  wire logic signed [CB-1:0] i_sx2,
    input  wire logic signed [CB-1:0] i_sy2,
    input  wire logic signed [CB-1:0] i_px,
    input  wire logic signed [CB-1:0] i_py,
    output logic                      o_valid,
    output logic                      o_tag,
    output logic [4*CB+1:0]           o_num,
    output logic [2*CB:0]             o_den
);

    localparam int DW = CB + 1;
    localparam int PW = 2 * CB + 2;
    localparam int SW = 2 * CB + 3;
    localparam int MW = 2 * CB + 1;
    localparam int LB = CB + 1;
    localparam int HB = CB;
    localparam int LLW = 2 * LB;
    localparam int LHW = LB + HB;
    localparam int HHW = 2 * HB;
    localparam int NW = 4 * CB + 2;

    logic [6:1] r_v;
    logic [6:1] r_tg;

    logic signed [DW-1:0] r1_dx, r1_dy, r1_qx, r1_qy, r1_rx, r1_ry;
    logic signed [PW-1:0] r2_xx, r2_yy, r2_tx, r2_ty, r2_cx, r2_cy;
    logic signed [PW-1:0] r2_qq, r2_pp, r2_rr, r2_ss;
    logic signed [SW-1:0] r3_len2, r3_t, r3_cr, r3_d1, r3_d2;
    logic                 r4_sel;
    logic [MW-1:0]        r4_cmag, r4_near, r4_len2;
    logic                 r5_sel;
    logic [MW-1:0]        r5_near, r5_len2;
    logic [LLW-1:0]       r5_ll;
    logic [LHW-1:0]       r5_lh;
    logic [HHW-1:0]       r5_hh;

    logic signed [SW-1:0] cabs;
    logic [LB-1:0]        c_lo;
    logic [HB-1:0]        c_hi;
    logic [NW-1:0]        full;

    assign cabs = r3_cr[SW-1] ? -r3_cr : r3_cr;
    assign c_lo = r4_cmag[LB-1:0];
    assign c_hi = r4_cmag[MW-1:LB];
    assign full = (NW'(r5_hh) << LLW) + (NW'(r5_lh) << (LB + 1)) + NW'(r5_ll);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[5:1], i_valid};
        end
        r_tg <= {r_tg[5:1], i_tag};

        // differences
        r1_dx <= DW'(i_sx2) - DW'(i_sx1);
        r1_dy <= DW'(i_sy2) - DW'(i_sy1);
        r1_qx <= DW'(i_px) - DW'(i_sx1);
        r1_qy <= DW'(i_py) - DW'(i_sy1);
        r1_rx <= DW'(i_px) - DW'(i_sx2);
        r1_ry <= DW'(i_py) - DW'(i_sy2);

        // products
        r2_xx <= PW'(r1_dx) * PW'(r1_dx);
        r2_yy <= PW'(r1_dy) * PW'(r1_dy);
        r2_tx <= PW'(r1_qx) * PW'(r1_dx);
        r2_ty <= PW'(r1_qy) * PW'(r1_dy);
        r2_cx <= PW'(r1_qx) * PW'(r1_dy);
        r2_cy <= PW'(r1_qy) * PW'(r1_dx);
        r2_qq <= PW'(r1_qx) * PW'(r1_qx);
        r2_pp <= PW'(r1_qy) * PW'(r1_qy);
        r2_rr <= PW'(r1_rx) * PW'(r1_rx);
        r2_ss <= PW'(r1_ry) * PW'(r1_ry);

        // length, dot, cross, endpoint distances
        r3_len2 <= SW'(r2_xx) + SW'(r2_yy);
        r3_t    <= SW'(r2_tx) + SW'(r2_ty);
        r3_cr   <= SW'(r2_cx) - SW'(r2_cy);
        r3_d1   <= SW'(r2_qq) + SW'(r2_pp);
        r3_d2   <= SW'(r2_rr) + SW'(r2_ss);

        // zero length or projection off the segment: nearer endpoint
        r4_sel  <= (r3_len2 == '0) || r3_t[SW-1] || (r3_t > r3_len2);
        r4_cmag <= cabs[MW-1:0];
        r4_near <= (r3_d1 < r3_d2) ? r3_d1[MW-1:0] : r3_d2[MW-1:0];
        r4_len2 <= r3_len2[MW-1:0];

        // square of the cross product in partial products
        r5_sel  <= r4_sel;
        r5_near <= r4_near;
        r5_len2 <= r4_len2;
        r5_ll   <= LLW'(c_lo) * LLW'(c_lo);
        r5_lh   <= LHW'(c_lo) * LHW'(c_hi);
        r5_hh   <= HHW'(c_hi) * HHW'(c_hi);

        o_num <= r5_sel ? NW'(r5_near) : full;
        o_den <= r5_sel ? MW'(1) : r5_len2;
    end

    assign o_valid = r_v[6];
    assign o_tag = r_tg[6];

endmodule

`default_nettype wire

[design/sd_root.sv]
// pipelined rounded square root of a ratio, one result bit per stage
`default_nettype none

module sd_root #(
    parameter int CB = sd_pkg::COORD_BITS_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire logic             i_tag,
    input  wire logic [4*CB+1:0]  i_num,
    input  wire logic [2*CB:0]    i_den,
    output logic                  o_valid,
    output logic                  o_tag,
    output logic [CB:0]           o_dist
);

    localparam int MB = CB + 2;
    localparam int NW = 4 * CB + 2;
    localparam int MW = 2 * CB + 1;
    localparam int W = 4 * CB + 10;
    localparam int DW = 3 * CB + 6;

    // residue e = 4 num - (2m+1)^2 den, d = (2m+1) den, t = d + den * 2^k
    logic [W-1:0]  r_e   [0:MB];
    logic [DW-1:0] r_d   [0:MB];
    logic [DW-1:0] r_t   [0:MB];
    logic [MW-1:0] r_den [0:MB];
    logic [DW-1:0] r_den5[0:MB];
    logic [MB-1:0] r_m   [0:MB];
    logic          r_pos [0:MB];
    logic          r_v   [0:MB];
    logic          r_tg  [0:MB];

    logic [W-1:0]  e0;
    logic [MB:0]   m_inc;

    assign e0 = (W'(i_num) << 2) - W'(i_den);
    assign m_inc = {1'b0, r_m[MB]} + (MB + 1)'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
            o_valid <= r_v[MB];
        end
        r_tg[0]   <= i_tag;
        r_e[0]    <= e0;
        r_pos[0]  <= !e0[W-1];
        r_den[0]  <= i_den;
        r_den5[0] <= DW'(i_den) + (DW'(i_den) << 2);
        r_d[0]    <= DW'(i_den);
        r_t[0]    <= DW'(i_den) + (DW'(i_den) << (MB - 1));
        r_m[0]    <= '0;

        o_tag  <= r_tg[MB];
        o_dist <= r_pos[MB] ? m_inc[CB:0] : '0;
    end

    for (genvar j = 1; j <= MB; j++) begin : g_stage
        localparam int K = MB - j;

        logic [W-1:0]  delta;
        logic [W-1:0]  cand;
        logic          ok;
        logic [DW-1:0] dn;
        logic [DW-1:0] tn;
        logic [MB-1:0] mn;

        assign delta = W'(r_t[j-1]) << (K + 2);
        assign cand = r_e[j-1] - delta;
        assign ok = !cand[W-1];
        assign dn = ok ? r_d[j-1] + (DW'(r_den[j-1]) << (K + 1)) : r_d[j-1];

        if (K > 0) begin : g_next
            assign tn = ok ? r_d[j-1] + (r_den5[j-1] << (K - 1))
                           : r_d[j-1] + (DW'(r_den[j-1]) << (K - 1));
        end else begin : g_last
            assign tn = r_t[j-1];
        end

        always_comb begin
            mn = r_m[j-1];
            mn[K] = ok;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else begin
                r_v[j] <= r_v[j-1];
            end
            r_tg[j]   <= r_tg[j-1];
            r_pos[j]  <= r_pos[j-1];
            r_e[j]    <= ok ? cand : r_e[j-1];
            r_d[j]    <= dn;
            r_t[j]    <= tn;
            r_den[j]  <= r_den[j-1];
            r_den5[j] <= r_den5[j-1];
            r_m[j]    <= mn;
        end
    end

endmodule

`default_nettype wire

[design/segment_distance.sv]
// top level: distance from segment a to a point or to segment b
// throughput: one word per cycle, busy stays low, nothing ever stalls
// depth grows with COORD_BITS through the square root pipeline, one result bit per stage
// reset: synchronous active low, clears the valid bits only; words in flight are dropped
// the receiver cannot stall, results must be taken in the strobe cycle
`default_nettype none

module segment_distance #(
    parameter int COORD_BITS = sd_pkg::COORD_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic                         i_opcode,
    input  wire logic signed [COORD_BITS-1:0] i_a_start_x,
    input  wire logic signed [COORD_BITS-1:0] i_a_start_y,
    input  wire logic signed [COORD_BITS-1:0] i_a_end_x,
    input  wire logic signed [COORD_BITS-1:0] i_a_end_y,
    input  wire logic signed [COORD_BITS-1:0] i_b_start_x,
    input  wire logic signed [COORD_BITS-1:0] i_b_start_y,
    input  wire logic signed [COORD_BITS-1:0] i_b_end_x,
    input  wire logic signed [COORD_BITS-1:0] i_b_end_y,
    output logic [COORD_BITS:0]               o_distance,
    output logic                              o_degenerate,
    output logic                              o_done
);

    localparam int CB = COORD_BITS;

    // input word register
    logic                 r_v0;
    logic                 r_op;
    logic signed [CB-1:0] r_ax1, r_ay1, r_ax2, r_ay2;
    logic signed [CB-1:0] r_bx1, r_by1, r_bx2, r_by2;

    // per job: segment and point
    logic signed [CB-1:0] j_sx1[4], j_sy1[4], j_sx2[4], j_sy2[4], j_px[4], j_py[4];
    logic                 degen;

    logic [3:0]    p_v, p_tg, q_v, q_tg;
    logic [4*CB+1:0] p_num[4];
    logic [2*CB:0]   p_den[4];
    logic [CB:0]     q_dist[4];

    // min tree
    logic          r_v1, r_dg1, r_v2, r_dg2;
    logic [CB:0]   r_m01, r_m23, r_dist;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v0 <= start && !busy;
            r_v1 <= &q_v;
            r_v2 <= r_v1;
        end
        r_op  <= i_opcode;
        r_ax1 <= i_a_start_x;
        r_ay1 <= i_a_start_y;
        r_ax2 <= i_a_end_x;
        r_ay2 <= i_a_end_y;
        r_bx1 <= i_b_start_x;
        r_by1 <= i_b_start_y;
        r_bx2 <= i_b_end_x;
        r_by2 <= i_b_end_y;

        r_m01 <= (q_dist[0] < q_dist[1]) ? q_dist[0] : q_dist[1];
        r_m23 <= (q_dist[2] < q_dist[3]) ? q_dist[2] : q_dist[3];
        r_dg1 <= |q_tg;
        r_dist <= (r_m01 < r_m23) ? r_m01 : r_m23;
        r_dg2 <= r_dg1;
    end

    // point query runs the same job in all four lanes, so the min is that job
    always_comb begin
        degen = (r_ax1 == r_ax2) && (r_ay1 == r_ay2);
        for (int i = 0; i < 4; i++) begin
            j_sx1[i] = r_ax1;
            j_sy1[i] = r_ay1;
            j_sx2[i] = r_ax2;
            j_sy2[i] = r_ay2;
            j_px[i]  = r_bx1;
            j_py[i]  = r_by1;
        end
        if (r_op == sd_pkg::OP_SEGMENT) begin
            degen = degen || ((r_bx1 == r_bx2) && (r_by1 == r_by2));
            // a endpoints against segment b
            for (int i = 0; i < 2; i++) begin
                j_sx1[i] = r_bx1;
                j_sy1[i] = r_by1;
                j_sx2[i] = r_bx2;
                j_sy2[i] = r_by2;
            end
            j_px[0] = r_ax1;
            j_py[0] = r_ay1;
            j_px[1] = r_ax2;
            j_py[1] = r_ay2;
            // b end against segment a
            j_px[3] = r_bx2;
            j_py[3] = r_by2;
        end
    end

    for (genvar i = 0; i < 4; i++) begin : g_lane
        sd_prep #(.CB(CB)) u_prep (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (r_v0),
            .i_tag   (degen),
            .i_sx1   (j_sx1[i]),
            .i_sy1   (j_sy1[i]),
            .i_sx2   (j_sx2[i]),
            .i_sy2   (j_sy2[i]),
            .i_px    (j_px[i]),
            .i_py    (j_py[i]),
            .o_valid (p_v[i]),
            .o_tag   (p_tg[i]),
            .o_num   (p_num[i]),
            .o_den   (p_den[i])
        );

        sd_root #(.CB(CB)) u_root (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (p_v[i]),
            .i_tag   (p_tg[i]),
            .i_num   (p_num[i]),
            .i_den   (p_den[i]),
            .o_valid (q_v[i]),
            .o_tag   (q_tg[i]),
            .o_dist  (q_dist[i])
        );
    end

    assign o_done = r_v2;
    assign o_distance = r_dist;
    assign o_degenerate = r_dg2;

endmodule

`default_nettype wire

[design/sd_check.sv]
// port level checks for the segment distance block, bound to the top level
`default_nettype none

module sd_check #(
    parameter int COORD_BITS = sd_pkg::COORD_BITS_DEF
) (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         start,
    input wire logic                         busy,
    input wire logic                         i_opcode,
    input wire logic signed [COORD_BITS-1:0] i_a_start_x,
    input wire logic signed [COORD_BITS-1:0] i_a_start_y,
    input wire logic signed [COORD_BITS-1:0] i_a_end_x,
    input wire logic signed [COORD_BITS-1:0] i_a_end_y,
    input wire logic signed [COORD_BITS-1:0] i_b_start_x,
    input wire logic signed [COORD_BITS-1:0] i_b_start_y,
    input wire logic signed [COORD_BITS-1:0] i_b_end_x,
    input wire logic signed [COORD_BITS-1:0] i_b_end_y,
    input wire logic [COORD_BITS:0]          o_distance,
    input wire logic                         o_degenerate,
    input wire logic                         o_done
);

    localparam int LAT = sd_pkg::latency(COORD_BITS);

    // every word taken in gives a result strobe, at the delay that the package latency function returns
    a_start_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##LAT o_done)
        else $error("missing result strobe");

    // no strobe without a word taken in at that delay before it
    a_done_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start, LAT))
        else $error("result strobe without a word");

    // point query with a zero length segment a reports degenerate
    a_degen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && $past(i_opcode == sd_pkg::OP_POINT && i_a_start_x == i_a_end_x
                        && i_a_start_y == i_a_end_y, LAT) |-> o_degenerate)
        else $error("degenerate flag missing");

    // point on the start of segment a is at distance zero
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && $past(i_opcode == sd_pkg::OP_POINT && i_a_start_x == i_b_start_x
                        && i_a_start_y == i_b_start_y, LAT) |-> o_distance == '0)
        else $error("nonzero distance for a point on the segment start");

endmodule

bind segment_distance sd_check #(.COORD_BITS(COORD_BITS)) u_sd_check (.*);

`default_nettype wire

[test/tb_segment_distance.sv]
// testbench for segment_distance: directed and random distance queries against a local predictor
`timescale 1ns / 1ps

module tb_segment_distance;

    localparam int CB = 16;
    localparam int LAT = CB + 13;
    localparam int CYCLE_LIMIT = 200000;

    // one query word as driven onto the ports
    typedef struct {
        logic                 op;
        logic signed [CB-1:0] ax1, ay1, ax2, ay2, bx1, by1, bx2, by2;
    } query_t;

    typedef struct {
        logic [CB:0] gap;
        logic        degen;
    } answer_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic                 i_opcode = sd_pkg::OP_POINT;
    logic signed [CB-1:0] i_a_start_x = '0, i_a_start_y = '0, i_a_end_x = '0, i_a_end_y = '0;
    logic signed [CB-1:0] i_b_start_x = '0, i_b_start_y = '0, i_b_end_x = '0, i_b_end_y = '0;
    logic [CB:0]          o_distance;
    logic                 o_degenerate;
    logic                 o_done;

    segment_distance #(.COORD_BITS(CB)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_opcode(i_opcode),
        .i_a_start_x(i_a_start_x), .i_a_start_y(i_a_start_y),
        .i_a_end_x(i_a_end_x), .i_a_end_y(i_a_end_y),
        .i_b_start_x(i_b_start_x), .i_b_start_y(i_b_start_y),
        .i_b_end_x(i_b_end_x), .i_b_end_y(i_b_end_y),
        .o_distance(o_distance), .o_degenerate(o_degenerate), .o_done(o_done)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    answer_t pending_answers[$];
    int      n_sent = 0, n_taken = 0, n_errors = 0, n_degen = 0;
    int      cycles = 0;
    bit      idle_on = 1'b1;

    // ---------------------------------------------------------------
    // predictor: exact integer geometry, rounded square root of a ratio
    // ---------------------------------------------------------------

    // smallest r with (2r+1)^2 * den > 4 * num
    function automatic longint unsigned root_of_ratio(logic [127:0] num, logic [127:0] den);
        longint unsigned lo, hi, mid;
        logic [127:0]    odd, lhs;
        lo = 0;
        hi = 64'd3 << CB;
        while (lo < hi) begin
            mid = lo + ((hi - lo) >> 1);
            odd = 128'(2 * mid + 1);
            lhs = odd * odd * den;
            if (lhs > (num << 2)) hi = mid;
            else lo = mid + 1;
        end
        return lo;
    endfunction

    function automatic longint unsigned span(longint x1, longint y1, longint x2, longint y2);
        longint dx, dy;
        dx = x2 - x1;
        dy = y2 - y1;
        return root_of_ratio(128'(dx * dx + dy * dy), 128'd1);
    endfunction

    // distance from point p to segment a1-a2; a zero-length segment means its start point
    function automatic longint unsigned reach(longint ax1, longint ay1, longint ax2, longint ay2,
                                              longint px, longint py);
        longint          dx, dy, qx, qy, len2, proj, cr;
        longint unsigned d1, d2;
        logic [127:0]    cw;
        dx = ax2 - ax1;
        dy = ay2 - ay1;
        qx = px - ax1;
        qy = py - ay1;
        len2 = dx * dx + dy * dy;
        if (len2 == 0) return span(ax1, ay1, px, py);
        proj = qx * dx + qy * dy;
        // projection falls off either end: nearer endpoint wins
        if (proj < 0 || proj > len2) begin
            d1 = span(ax1, ay1, px, py);
            d2 = span(ax2, ay2, px, py);
            return (d1 < d2) ? d1 : d2;
        end
        cr = qx * dy - qy * dx;
        if (cr < 0) cr = -cr;
        cw = 128'(cr);
        return root_of_ratio(cw * cw, 128'(len2));
    endfunction

    function automatic answer_t nearest_distance(query_t q);
        answer_t         r;
        longint unsigned best, d;
        bit              a_zero, b_zero;
        a_zero = (q.ax1 == q.ax2) && (q.ay1 == q.ay2);
        b_zero = (q.bx1 == q.bx2) && (q.by1 == q.by2);
        if (q.op == sd_pkg::OP_POINT) begin
            best = reach(q.ax1, q.ay1, q.ax2, q.ay2, q.bx1, q.by1);
            r.degen = a_zero;
        end else begin
            // four endpoint-to-segment distances, crossings not detected
            best = reach(q.bx1, q.by1, q.bx2, q.by2, q.ax1, q.ay1);
            d = reach(q.bx1, q.by1, q.bx2, q.by2, q.ax2, q.ay2);
            if (d < best) best = d;
            d = reach(q.ax1, q.ay1, q.ax2, q.ay2, q.bx1, q.by1);
            if (d < best) best = d;
            d = reach(q.ax1, q.ay1, q.ax2, q.ay2, q.bx2, q.by2);
            if (d < best) best = d;
            r.degen = a_zero || b_zero;
        end
        r.gap = best[CB:0];
        return r;
    endfunction

    // ---------------------------------------------------------------
    // result checker: every strobe must match the oldest expectation
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        answer_t want;
        cycles <= cycles + 1;
        if (i_rst_n && o_done) begin
            if (pending_answers.size() == 0) begin
                n_errors = n_errors + 1;
                if (n_errors <= 10)
                    $display("error: unexpected result dist=%0d degen=%0b", o_distance, o_degenerate);
            end else begin
                want = pending_answers.pop_front();
                n_taken = n_taken + 1;
                if (o_distance !== want.gap || o_degenerate !== want.degen) begin
                    n_errors = n_errors + 1;
                    if (n_errors <= 10)
                        $display("error: result %0d dist exp %0d got %0d, degen exp %0b got %0b",
                                 n_taken, want.gap, o_distance, want.degen, o_degenerate);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("tb_segment_distance NOT OK");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------

    // drive one word at the falling edge, hold until an edge with busy low takes it
    task automatic send_word(query_t q);
        answer_t a;
        @(negedge i_clk);
        start = 1'b1;
        i_opcode = q.op;
        i_a_start_x = q.ax1;
        i_a_start_y = q.ay1;
        i_a_end_x = q.ax2;
        i_a_end_y = q.ay2;
        i_b_start_x = q.bx1;
        i_b_start_y = q.by1;
        i_b_end_x = q.bx2;
        i_b_end_y = q.by2;
        do @(posedge i_clk); while (busy !== 1'b0);
        a = nearest_distance(q);
        if (a.degen) n_degen = n_degen + 1;
        pending_answers.push_back(a);
        n_sent = n_sent + 1;
        // random idle gaps after some words
        if (idle_on && $urandom_range(99) < 8) begin
            @(negedge i_clk);
            start = 1'b0;
            i_opcode = 1'($urandom);
            repeat ($urandom_range(3)) @(negedge i_clk);
        end
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        start = 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
    endtask

    function automatic query_t mk(logic op, int ax1, int ay1, int ax2, int ay2,
                                  int bx1, int by1, int bx2, int by2);
        query_t q;
        q.op = op;
        q.ax1 = CB'(ax1); q.ay1 = CB'(ay1); q.ax2 = CB'(ax2); q.ay2 = CB'(ay2);
        q.bx1 = CB'(bx1); q.by1 = CB'(by1); q.bx2 = CB'(bx2); q.by2 = CB'(by2);
        return q;
    endfunction

    // coordinate drawn from a small box, a wider box, the full range, or an extreme
    function automatic int pick_coord(int mode);
        case (mode)
            0: return $urandom_range(64) - 32;
            1: return $urandom_range(2048) - 1024;
            2: return $urandom_range(1) ? 32767 - $urandom_range(3) : -32768 + $urandom_range(3);
            default: return int'($urandom_range(65535)) - 32768;
        endcase
    endfunction

    function automatic query_t random_query();
        query_t q;
        int     mode, shape;
        mode = $urandom_range(5);
        q = mk(1'($urandom), pick_coord(mode), pick_coord(mode), pick_coord(mode),
               pick_coord(mode), pick_coord(mode), pick_coord(mode), pick_coord(mode),
               pick_coord(mode));
        shape = $urandom_range(9);
        case (shape)
            0: begin q.ax2 = q.ax1; q.ay2 = q.ay1; end          // zero-length a
            1: begin q.bx2 = q.bx1; q.by2 = q.by1; end          // zero-length b
            2: begin q.bx1 = q.ax1; q.by1 = q.ay1; end          // point on an endpoint
            3: begin q.ay2 = q.ay1; q.by1 = q.ay1; end          // horizontal a, b start on its line
            default: ;
        endcase
        return q;
    endfunction

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------
    task automatic test_point_cases();
        send_word(mk(sd_pkg::OP_POINT, 0, 0, 160, 0, 80, 48, 0, 0));          // foot inside
        send_word(mk(sd_pkg::OP_POINT, 0, 0, 160, 0, -48, 64, 0, 0));         // before start
        send_word(mk(sd_pkg::OP_POINT, 0, 0, 160, 0, 208, -64, 0, 0));        // past end
        send_word(mk(sd_pkg::OP_POINT, 0, 0, 160, 0, 0, 33, 0, 0));           // projects on start
        send_word(mk(sd_pkg::OP_POINT, 0, 0, 160, 0, 160, -21, 0, 0));        // projects on end
        send_word(mk(sd_pkg::OP_POINT, 7, -9, 7, -9, 30, 40, 5, 5));          // zero-length a
        send_word(mk(sd_pkg::OP_POINT, 3, 3, 3, 3, 3, 3, 0, 0));              // all coincident
        send_word(mk(sd_pkg::OP_POINT, 10, 10, 50, 30, 30, 20, -1, -1));      // point on segment
    endtask

    task automatic test_extremes();
        send_word(mk(sd_pkg::OP_POINT, -32768, -32768, -32768, -32768, 32767, 32767, 0, 0));
        send_word(mk(sd_pkg::OP_POINT, -32768, 32767, 32767, -32768, 32767, 32767,
                     -32768, -32768));
        send_word(mk(sd_pkg::OP_POINT, 32767, 32767, -32768, -32768, -32768, 32767,
                     32767, 32767));
        send_word(mk(sd_pkg::OP_SEGMENT, -32768, -32768, -32768, -32768, 32767, 32767,
                     32767, 32767));
        send_word(mk(sd_pkg::OP_SEGMENT, -32768, -32768, -32767, -32768, 32767, 32767,
                     32766, 32767));
        send_word(mk(sd_pkg::OP_POINT, -1, -1, -1, -1, -1, -1, -1, -1));
    endtask

    task automatic test_segment_cases();
        send_word(mk(sd_pkg::OP_SEGMENT, 0, 0, 160, 0, 40, 32, 120, 64));      // parallel-ish
        send_word(mk(sd_pkg::OP_SEGMENT, 0, 0, 160, 160, 0, 160, 160, 0));     // crossing
        send_word(mk(sd_pkg::OP_SEGMENT, 0, 0, 160, 0, 200, 10, 300, 90));     // disjoint ends
        send_word(mk(sd_pkg::OP_SEGMENT, 5, 5, 5, 5, 0, 0, 100, 0));           // a zero-length
        send_word(mk(sd_pkg::OP_SEGMENT, 0, 0, 100, 0, 50, -30, 50, -30));     // b zero-length
        send_word(mk(sd_pkg::OP_SEGMENT, 9, 9, 9, 9, -9, -9, -9, -9));         // both zero-length
        send_word(mk(sd_pkg::OP_SEGMENT, 0, 0, 64, 0, 32, 0, 96, 0));          // collinear overlap
        send_word(mk(sd_pkg::OP_SEGMENT, 0, 0, 64, 0, 64, 0, 64, 64));         // shared endpoint
    endtask

    task automatic test_random(int count);
        repeat (count) send_word(random_query());
    endtask

    // a stretch with the sender never pausing
    task automatic test_back_to_back(int count);
        idle_on = 1'b0;
        test_random(count);
        idle_on = 1'b1;
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_point_cases();
        test_extremes();
        test_segment_cases();
        wait_drained();            // sender holds off until the pipe is empty
        test_random(250);
        test_back_to_back(120);
        test_random(160);

        wait_drained();
        repeat (LAT + 10) @(posedge i_clk);
        $display("sent %0d queries (point and segment, incl. extremes), %0d results checked",
                 n_sent, n_taken);
        $display("%0d queries with a zero-length segment, %0d mismatches", n_degen, n_errors);
        if (n_errors == 0 && pending_answers.size() == 0)
            $display("tb_segment_distance OK");
        else
            $display("tb_segment_distance NOT OK");
        $finish;
    end

endmodule
